// ===== rtl/kepler_pkg.sv =====
// ----------------------------------------------------------------------------
// Kepler solver package
// Shared types and constants for the Newton-Raphson eccentric anomaly solver.
// ----------------------------------------------------------------------------
package kepler_pkg;

  localparam int CordicSteps = 30;
  localparam int TrigFrac = 30;

  localparam logic signed [35:0] PiQ30 = 36'sh0C90FDAA2;
  localparam logic signed [35:0] HalfPiQ30 = 36'sh06487ED51;
  localparam logic signed [35:0] TwoPiQ30 = 36'sh1921FB544;
  localparam logic signed [35:0] CordicGain = 36'sh026DD3B6A;
  localparam logic [63:0] PiQ60 = 64'h3243F6A8885A308D;

  localparam logic [0:0] REG_TOLERANCE = 1'b0;
  localparam logic [0:0] REG_ITER_LIMIT = 1'b1;

  typedef struct packed {
    logic load;
    logic trig_start;
    logic step_start;
    logic apply_update;
    logic apply_restart;
  } kes_cmd_t;

  typedef struct packed {
    logic trig_done;
    logic step_done;
    logic diff_small;
  } kes_status_t;

  function automatic logic signed [35:0] atan_q30(input logic [4:0] i);
    logic signed [35:0] r;
    begin
      unique case (i)
        5'd0: r = 36'sh3243F6A8;   5'd1: r = 36'sh1DAC6705;
        5'd2: r = 36'sh0FADBAFC;   5'd3: r = 36'sh07F56EA6;
        5'd4: r = 36'sh03FEAB76;   5'd5: r = 36'sh01FFD55B;
        5'd6: r = 36'sh00FFFAAA;   5'd7: r = 36'sh007FFF55;
        5'd8: r = 36'sh003FFFEA;   5'd9: r = 36'sh001FFFFD;
        5'd10: r = 36'sh000FFFFF;  5'd11: r = 36'sh0007FFFF;
        5'd12: r = 36'sh0003FFFF;  5'd13: r = 36'sh0001FFFF;
        5'd14: r = 36'sh0000FFFF;  5'd15: r = 36'sh00007FFF;
        5'd16: r = 36'sh00003FFF;  5'd17: r = 36'sh00001FFF;
        5'd18: r = 36'sh00000FFF;  5'd19: r = 36'sh000007FF;
        5'd20: r = 36'sh000003FF;  5'd21: r = 36'sh000001FF;
        5'd22: r = 36'sh000000FF;  5'd23: r = 36'sh0000007F;
        5'd24: r = 36'sh0000003F;  5'd25: r = 36'sh0000001F;
        5'd26: r = 36'sh0000000F;  5'd27: r = 36'sh00000008;
        5'd28: r = 36'sh00000004;  5'd29: r = 36'sh00000002;
        default: r = '0;
      endcase
      return r;
    end
  endfunction

endpackage

// ===== rtl/kepler_eccentric_anomaly_solver.sv =====
// ----------------------------------------------------------------------------
// Kepler eccentric anomaly solver
// Newton-Raphson solution of E - e*sin(E) = M in Q4.28 fixed point.
// ----------------------------------------------------------------------------
// Each Newton step runs range reduction, 30 CORDIC steps, the multiplies and
// a serial divider that forms 64 quotient bits.
// Throughput: one word at a time; the next is taken after the result leaves.
// Reset: synchronous; tolerance 1, iteration_limit 100, controller idle.
module kepler_eccentric_anomaly_solver #(
  parameter int FRAC_BITS = 28
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] mean_anomaly,
  input  logic [27:0]        eccentricity,
  input  logic signed [31:0] initial_guess,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] eccentric_anomaly,
  output logic               converged,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [0:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam logic signed [63:0] NegFull = -(64'sd1 <<< FRAC_BITS);
  localparam logic signed [31:0] NegOne =
    (NegFull < -64'sh80000000) ? 32'sh80000000 : NegFull[31:0];

  logic [20:0]             tolerance;
  logic [7:0]              iteration_limit;
  kepler_pkg::kes_cmd_t    cmd;
  kepler_pkg::kes_status_t status;
  logic signed [31:0]      estimate;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= 21'd1;
      iteration_limit <= 8'd100;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        kepler_pkg::REG_TOLERANCE: tolerance <= cfg_data[20:0];
        kepler_pkg::REG_ITER_LIMIT: iteration_limit <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  kepler_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready),
    .iteration_limit(iteration_limit), .status(status), .cmd(cmd),
    .converged(converged)
  );

  kepler_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .mean_anomaly(mean_anomaly), .eccentricity(eccentricity),
    .initial_guess(initial_guess), .tolerance(tolerance), .estimate(estimate)
  );

  assign eccentric_anomaly = converged ? estimate : NegOne;

endmodule

// ===== rtl/kepler_cordic.sv =====
// ----------------------------------------------------------------------------
// Kepler CORDIC
// Range reduction and a 30-step rotation CORDIC, one step per cycle.
// ----------------------------------------------------------------------------
module kepler_cordic #(
  parameter int FRAC_BITS = 28
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [31:0]  angle,
  output logic                done,
  output logic signed [35:0]  sin_q30,
  output logic signed [35:0]  cos_q30
);

  localparam int Sh = FRAC_BITS - kepler_pkg::TrigFrac;

  logic signed [63:0] r0;
  logic signed [63:0] t0;
  logic signed [35:0] red;
  logic signed [35:0] red_next;
  logic signed [35:0] x;
  logic signed [35:0] y;
  logic signed [35:0] z;
  logic               flip;
  logic               flip_next;
  logic               busy;
  logic               reducing;
  logic [4:0]         step;

  always_comb begin
    if (Sh >= 0) begin
      r0 = 64'(signed'(angle)) >>> Sh;
    end else begin
      r0 = 64'(signed'(angle)) <<< (-Sh);
    end
    t0 = r0;
  end

  // one 2*pi reduction per cycle gives [-pi, pi); here fold to [-pi/2, pi/2]
  always_comb begin
    red_next = red;
    flip_next = 1'b0;
    if (red > kepler_pkg::HalfPiQ30) begin
      red_next = kepler_pkg::PiQ30 - red;
      flip_next = 1'b1;
    end else if (red < -kepler_pkg::HalfPiQ30) begin
      red_next = -kepler_pkg::PiQ30 - red;
      flip_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      reducing <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        reducing <= 1'b1;
        red <= t0[35:0];
      end else if (busy && reducing) begin
        if (red >= kepler_pkg::PiQ30) begin
          red <= red - kepler_pkg::TwoPiQ30;
        end else if (red < -kepler_pkg::PiQ30) begin
          red <= red + kepler_pkg::TwoPiQ30;
        end else begin
          reducing <= 1'b0;
          flip <= flip_next;
          x <= kepler_pkg::CordicGain;
          y <= '0;
          z <= red_next;
          step <= '0;
        end
      end else if (busy) begin
        if (z >= 0) begin
          x <= x - (y >>> step);
          y <= y + (x >>> step);
          z <= z - kepler_pkg::atan_q30(step);
        end else begin
          x <= x + (y >>> step);
          y <= y - (x >>> step);
          z <= z + kepler_pkg::atan_q30(step);
        end
        if (step == 5'(kepler_pkg::CordicSteps - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        step <= step + 5'd1;
      end
    end
  end

  assign sin_q30 = y;
  assign cos_q30 = flip ? -x : x;

endmodule

// ===== rtl/kepler_datapath.sv =====
// ----------------------------------------------------------------------------
// Kepler datapath
// Estimate registers, Newton residual, serial divider and update logic.
// ----------------------------------------------------------------------------
module kepler_datapath #(
  parameter int FRAC_BITS = 28
) (
  input  logic                    clk,
  input  logic                    rst,
  input  kepler_pkg::kes_cmd_t    cmd,
  output kepler_pkg::kes_status_t status,
  input  logic signed [31:0]      mean_anomaly,
  input  logic [27:0]             eccentricity,
  input  logic signed [31:0]      initial_guess,
  input  logic [20:0]             tolerance,
  output logic signed [31:0]      estimate
);

  localparam logic signed [63:0] PiFull =
    64'(kepler_pkg::PiQ60 >> (60 - FRAC_BITS));
  localparam logic signed [31:0] PiVal =
    (PiFull > 64'sh7FFFFFFF) ? 32'sh7FFFFFFF : PiFull[31:0];

  logic signed [31:0] ma;
  logic        [27:0] ecc;
  logic signed [35:0] s;
  logic signed [35:0] c;
  logic               trig_done;
  logic signed [65:0] es_prod;
  logic signed [65:0] ec_prod;
  logic signed [65:0] f;
  logic signed [65:0] den;
  logic        [96:0] rem;
  logic        [96:0] sh_rem;
  logic        [63:0] quo;
  logic        [31:0] dvs;
  logic        [6:0]  bitn;
  logic               neg;
  logic               dividing;
  logic               step_done;
  logic               mul_phase;
  logic signed [63:0] diff;
  logic        [63:0] mag;
  logic signed [64:0] upd;
  logic        [33:0] trial;

  kepler_cordic #(.FRAC_BITS(FRAC_BITS)) u_cordic (
    .clk(clk), .rst(rst), .start(cmd.trig_start), .angle(estimate),
    .done(trig_done), .sin_q30(s), .cos_q30(c)
  );

  always_comb begin
    f = 66'(signed'(estimate)) - (es_prod >>> kepler_pkg::TrigFrac)
        - 66'(signed'(ma));
    den = (66'sd1 <<< kepler_pkg::TrigFrac) - (ec_prod >>> FRAC_BITS);
    mag = diff[63] ? 64'(-diff) : 64'(diff);
    upd = 65'(signed'(estimate)) - 65'(signed'(diff));
    sh_rem = {rem[95:0], 1'b0};
    trial = {1'b0, sh_rem[96:64]} - {2'b00, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dividing <= 1'b0;
      step_done <= 1'b0;
      mul_phase <= 1'b0;
    end else begin
      step_done <= 1'b0;
      if (cmd.load) begin
        ma <= mean_anomaly;
        ecc <= eccentricity;
        estimate <= initial_guess;
      end
      if (trig_done) begin
        es_prod <= 66'(signed'({1'b0, ecc})) * 66'(s);
        ec_prod <= 66'(signed'({1'b0, ecc})) * 66'(c);
        mul_phase <= 1'b1;
      end else if (mul_phase) begin
        mul_phase <= 1'b0;
        neg <= f[65];
        rem <= 97'(f[65] ? -f : f) << kepler_pkg::TrigFrac;
        dvs <= (den < 66'sd1) ? 32'd1 : den[31:0];
        quo <= '0;
        bitn <= '0;
        dividing <= 1'b1;
      end else if (dividing) begin
        // restoring division, quotient bits from the top; remainder kept high
        if (!trial[33]) begin
          rem <= {trial[32:0], sh_rem[63:0]};
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= sh_rem;
          quo <= {quo[62:0], 1'b0};
        end
        if (bitn == 7'd63) begin
          dividing <= 1'b0;
          step_done <= 1'b1;
        end
        bitn <= bitn + 7'd1;
      end
      if (step_done) begin
        diff <= neg ? -$signed(quo) : $signed(quo);
      end
      if (cmd.apply_update) begin
        if (cmd.apply_restart) begin
          estimate <= PiVal;
        end else if (upd > 65'sh07FFFFFFF) begin
          estimate <= 32'sh7FFFFFFF;
        end else if (upd < -65'sh080000000) begin
          estimate <= 32'sh80000000;
        end else begin
          estimate <= upd[31:0];
        end
      end
    end
  end

  logic step_done_q;
  always_ff @(posedge clk) begin
    if (rst) begin
      step_done_q <= 1'b0;
    end else begin
      step_done_q <= step_done;
    end
  end

  // remainder is shifted into the top; its top 33 bits are tried against the divisor
  assign status.trig_done = trig_done;
  assign status.step_done = step_done_q;
  assign status.diff_small = (mag <= 64'(tolerance));

endmodule

// ===== rtl/kepler_ctrl.sv =====
// ----------------------------------------------------------------------------
// Kepler controller
// Sequences Newton steps, counts iterations and handles restart and failure.
// ----------------------------------------------------------------------------
module kepler_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  logic                    out_ready,
  input  logic [7:0]              iteration_limit,
  input  kepler_pkg::kes_status_t status,
  output kepler_pkg::kes_cmd_t    cmd,
  output logic                    converged
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_TRIG  = 3'd1;
  localparam logic [2:0] S_STEP  = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0] state;
  logic [8:0] count;
  logic       first_done;
  logic       go_on;

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign go_on = !status.diff_small && count <= {1'b0, iteration_limit};

  always_comb begin
    cmd = '0;
    cmd.load = in_valid && in_ready;
    cmd.trig_start = (state == S_TRIG);
    cmd.apply_update = (state == S_STEP && status.step_done && !first_done) ||
      (state == S_CHECK && go_on);
    cmd.apply_restart = (state == S_CHECK) && go_on &&
      count == {2'b0, iteration_limit[7:1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      first_done <= 1'b0;
      converged <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_TRIG;
            count <= '0;
            first_done <= 1'b0;
          end
        end
        S_TRIG: begin
          state <= S_STEP;
        end
        S_STEP: begin
          if (status.step_done) begin
            if (!first_done) begin
              first_done <= 1'b1;
              state <= S_TRIG;
            end else begin
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          if (go_on) begin
            count <= count + 9'd1;
            state <= S_TRIG;
          end else begin
            converged <= count < {1'b0, iteration_limit};
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) out_valid |-> !in_ready)
    else $error("busy with result pending");
  assert property (@(posedge clk) disable iff (rst)
    cmd.apply_restart |-> cmd.apply_update)
    else $error("restart without update");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && !out_ready) |=> state == S_OUT)
    else $error("result dropped");

endmodule
